/* rtl/core/bda_pkg.sv */
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and fixed constants of the banker's algorithm resource manager:
// field widths, stream packing, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package bda_pkg;

	// Fixed field widths
	localparam int MODE_W     = 2;
	localparam int PROC_W     = 4;
	localparam int AMT_W      = 8;
	localparam int TOT_W      = 12;
	localparam int KINDS      = 5;
	localparam int STATUS_W   = 2;
	localparam int CNT_OUT_W  = 5;
	localparam int CFG_IDX_W  = 3;

	// Stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 72;

	// Bit offsets inside the stream payloads
	localparam int IN_AMT_LSB     = PROC_W;
	localparam int IN_LIM_LSB     = PROC_W + KINDS * AMT_W;
	localparam int OUT_SAFE_BIT   = STATUS_W;
	localparam int OUT_CNT_LSB    = STATUS_W + 1;
	localparam int OUT_FREE_LSB   = STATUS_W + 1 + CNT_OUT_W;

	// Operation codes carried in the request
	localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SAFETY  = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DENY   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW_RD,
		ST_LOAD,
		ST_REQ,
		ST_SAFE_INIT,
		ST_SAFE_SCAN,
		ST_DONE
	} state_t;

endpackage

/* rtl/core/bankers_deadlock_avoidance.sv */
// ----------------------------------------------------------------------------
// bankers_deadlock_avoidance
// Banker's algorithm resource manager: loads process rows, grants or denies
// resource requests and runs the safety check over a per-row compare/add unit.
// ----------------------------------------------------------------------------
// One request is taken at a time. A load or a resource request passes from
// acceptance through row read, check and write-back, and result hand-off
// before the sequencer is idle again; an unused mode or an out-of-range
// process goes straight to the hand-off. A safety check seeds the scan, then
// examines the rows NUM_PROCESSES per pass over the process table, for 1 to
// NUM_PROCESSES passes, the last pass ending early once every process has
// finished, and then hands off the result. The single read port of the
// held/need row memory sets the pace: through it the shared row unit examines
// one process per cycle. The hand-off waits while the previous result still
// blocks the output register. A finished result waits in the output register,
// and the next request is accepted while it waits.
module bankers_deadlock_avoidance #(
	parameter int NUM_PROCESSES = 16,
	parameter int NUM_RESOURCES = 5,
	parameter int COUNT_WIDTH   = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// process, amount_0..amount_4, limit_0..limit_4, zero pad
	input  logic [bda_pkg::IN_DATA_W-1:0]     s_tdata,
	// mode
	input  logic [bda_pkg::MODE_W-1:0]        s_tuser,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status, safe, finished_count, free_0..free_4, zero pad
	output logic [bda_pkg::OUT_DATA_W-1:0]    m_tdata,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [bda_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bda_pkg::TOT_W-1:0]         cfg_data
);

	localparam int PW   = $clog2(NUM_PROCESSES);
	localparam int CNTW = $clog2(NUM_PROCESSES + 1);
	localparam int AW   = (COUNT_WIDTH < bda_pkg::AMT_W) ? COUNT_WIDTH : bda_pkg::AMT_W;
	localparam int VW   = ((COUNT_WIDTH > bda_pkg::TOT_W) ? COUNT_WIDTH : bda_pkg::TOT_W) + 1;

	typedef logic [NUM_RESOURCES-1:0][COUNT_WIDTH-1:0] row_t;
	typedef logic [NUM_RESOURCES-1:0][bda_pkg::TOT_W-1:0] vec_t;

	bda_pkg::state_t state_q, state_d;

	// captured request
	logic [bda_pkg::MODE_W-1:0] mode_q;
	logic [bda_pkg::PROC_W-1:0] proc_q;
	row_t                       amt_q;
	row_t                       lim_q;
	row_t                       amt_in;
	row_t                       lim_in;
	logic                       proc_in_ok;
	logic                       proc_ok_q;

	// configuration and bookkeeping
	vec_t                       total_q;
	vec_t                       colsum_q;
	vec_t                       work_q;
	vec_t                       free_w;
	logic [NUM_PROCESSES-1:0]   finished_q;
	logic [CNTW-1:0]            count_q;
	logic [CNTW-1:0]            count_next;
	logic                       progress_q;
	logic [bda_pkg::STATUS_W-1:0] status_q;

	// row memory
	row_t                       held_mem [NUM_PROCESSES];
	row_t                       need_mem [NUM_PROCESSES];
	logic [NUM_PROCESSES-1:0]   row_vld_q;
	logic [PW-1:0]              rd_addr;
	row_t                       held_raw_s1;
	row_t                       need_raw_s1;
	logic                       row_vld_s1;
	row_t                       held_row;
	row_t                       need_row;
	logic                       wr_en;
	row_t                       wr_held;
	row_t                       wr_need;

	// safety scan
	logic [PW-1:0]              rd_idx_q;
	logic [PW-1:0]              eval_idx_s1;
	logic                       eval_vld_s1;
	logic                       eval_last;
	logic                       fit;
	logic                       scan_stop;

	// shared row unit
	vec_t                       lane_sum;
	logic                       load_bad;
	logic                       req_bad;
	logic                       fit_ok;

	// output register
	logic                       m_valid_q;
	logic [bda_pkg::STATUS_W-1:0] res_status_q;
	logic                       res_safe_q;
	logic [bda_pkg::CNT_OUT_W-1:0] res_count_q;
	vec_t                       res_free_q;
	logic                       out_load;

	// Unpack the request lanes, masked to the count width
	always_comb begin
		for (int k = 0; k < NUM_RESOURCES; k++) begin
			amt_in[k] = COUNT_WIDTH'(s_tdata[bda_pkg::IN_AMT_LSB + k * bda_pkg::AMT_W +: AW]);
			lim_in[k] = COUNT_WIDTH'(s_tdata[bda_pkg::IN_LIM_LSB + k * bda_pkg::AMT_W +: AW]);
		end
	end

	assign proc_in_ok = (32'(s_tdata[bda_pkg::PROC_W-1:0]) < NUM_PROCESSES);
	assign s_tready   = (state_q == bda_pkg::ST_IDLE);

	// Free count per kind, saturating at zero
	always_comb begin
		for (int k = 0; k < NUM_RESOURCES; k++) begin
			free_w[k] = (colsum_q[k] >= total_q[k]) ? '0 : total_q[k] - colsum_q[k];
		end
	end

	// Row memory read address: the addressed process, or the scan pointer
	assign rd_addr = (state_q == bda_pkg::ST_ROW_RD) ? PW'(proc_q) : rd_idx_q;

	// Row memory: one read and one write port, rows read as zero until loaded
	always_ff @(posedge clk) begin
		held_raw_s1 <= held_mem[rd_addr];
		need_raw_s1 <= need_mem[rd_addr];
		if (wr_en) begin
			held_mem[PW'(proc_q)] <= wr_held;
			need_mem[PW'(proc_q)] <= wr_need;
		end
	end

	assign held_row = row_vld_s1 ? held_raw_s1 : '0;
	assign need_row = row_vld_s1 ? need_raw_s1 : '0;

	// Shared row unit: one add/subtract lane and four comparators per kind
	always_comb begin
		logic [VW-1:0] opa;
		logic [VW-1:0] opb;
		logic [VW-1:0] opc;
		logic [VW-1:0] sum_e;
		logic [VW-1:0] amt_e;
		logic [VW-1:0] bound_e;
		load_bad = 1'b0;
		req_bad  = 1'b0;
		fit_ok   = 1'b1;
		wr_held  = '0;
		wr_need  = '0;
		for (int k = 0; k < NUM_RESOURCES; k++) begin
			amt_e = VW'(amt_q[k]);
			if (state_q == bda_pkg::ST_SAFE_SCAN) begin
				opa = VW'(work_q[k]);
				opb = VW'(held_row[k]);
				opc = '0;
			end else begin
				opa = VW'(colsum_q[k]);
				opb = amt_e;
				opc = (state_q == bda_pkg::ST_LOAD) ? VW'(held_row[k]) : '0;
			end
			sum_e       = opa + opb - opc;
			lane_sum[k] = bda_pkg::TOT_W'(sum_e);
			bound_e     = (state_q == bda_pkg::ST_LOAD) ? VW'(lim_q[k]) : VW'(need_row[k]);
			if (amt_e > bound_e || sum_e > VW'(total_q[k])) begin
				load_bad = 1'b1;
			end
			if (amt_e > bound_e || amt_e > VW'(free_w[k])) begin
				req_bad = 1'b1;
			end
			if (VW'(need_row[k]) > VW'(work_q[k])) begin
				fit_ok = 1'b0;
			end
			if (state_q == bda_pkg::ST_LOAD) begin
				wr_held[k] = amt_q[k];
				wr_need[k] = lim_q[k] - amt_q[k];
			end else begin
				wr_held[k] = held_row[k] + amt_q[k];
				wr_need[k] = need_row[k] - amt_q[k];
			end
		end
	end

	// Safety scan decisions for the row now evaluated
	assign eval_last  = (eval_idx_s1 == PW'(NUM_PROCESSES - 1));
	assign fit        = eval_vld_s1 && !finished_q[eval_idx_s1] && fit_ok;
	assign count_next = count_q + CNTW'(fit);
	assign scan_stop  = eval_vld_s1 &&
		((count_next == CNTW'(NUM_PROCESSES)) || (eval_last && !(progress_q || fit)));
	assign out_load   = !m_valid_q || m_tready;

	// Next state and strobes
	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		case (state_q)
			bda_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						bda_pkg::MODE_LOAD,
						bda_pkg::MODE_REQUEST: state_d = proc_in_ok ? bda_pkg::ST_ROW_RD
						                                            : bda_pkg::ST_DONE;
						bda_pkg::MODE_SAFETY:  state_d = bda_pkg::ST_SAFE_INIT;
						default:               state_d = bda_pkg::ST_DONE;
					endcase
				end
			end
			bda_pkg::ST_ROW_RD: begin
				state_d = (mode_q == bda_pkg::MODE_LOAD) ? bda_pkg::ST_LOAD : bda_pkg::ST_REQ;
			end
			bda_pkg::ST_LOAD: begin
				wr_en   = !load_bad;
				state_d = bda_pkg::ST_DONE;
			end
			bda_pkg::ST_REQ: begin
				wr_en   = !req_bad;
				state_d = bda_pkg::ST_DONE;
			end
			bda_pkg::ST_SAFE_INIT: begin
				state_d = bda_pkg::ST_SAFE_SCAN;
			end
			bda_pkg::ST_SAFE_SCAN: begin
				if (scan_stop) begin
					state_d = bda_pkg::ST_DONE;
				end
			end
			bda_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = bda_pkg::ST_IDLE;
				end
			end
			default: state_d = bda_pkg::ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q    <= s_tuser;
			proc_q    <= s_tdata[bda_pkg::PROC_W-1:0];
			proc_ok_q <= proc_in_ok;
			amt_q     <= amt_in;
			lim_q     <= lim_in;
		end
	end

	// Hold the totals written over the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else begin
			for (int k = 0; k < NUM_RESOURCES; k++) begin
				if (cfg_we && cfg_index == bda_pkg::CFG_IDX_W'(k)) begin
					total_q[k] <= cfg_data;
				end
			end
		end
	end

	// Bookkeeping: column sums, row valid bits, status, safety scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colsum_q    <= '0;
			row_vld_q   <= '0;
			finished_q  <= '0;
			count_q     <= '0;
			progress_q  <= 1'b0;
			status_q    <= bda_pkg::STATUS_OK;
			rd_idx_q    <= '0;
			eval_idx_s1 <= '0;
			eval_vld_s1 <= 1'b0;
			row_vld_s1  <= 1'b0;
			work_q      <= '0;
		end else begin
			row_vld_s1  <= row_vld_q[rd_addr];
			eval_idx_s1 <= rd_addr;
			eval_vld_s1 <= (state_q == bda_pkg::ST_SAFE_SCAN) && !scan_stop;

			// start of a request: out-of-range processes fail here
			if (s_tvalid && s_tready) begin
				count_q <= '0;
				if (!proc_in_ok && s_tuser == bda_pkg::MODE_LOAD) begin
					status_q <= bda_pkg::STATUS_REJECT;
				end else if (!proc_in_ok && s_tuser == bda_pkg::MODE_REQUEST) begin
					status_q <= bda_pkg::STATUS_DENY;
				end else begin
					status_q <= bda_pkg::STATUS_OK;
				end
			end

			// commit or refuse a load or a request
			if (state_q == bda_pkg::ST_LOAD && load_bad) begin
				status_q <= bda_pkg::STATUS_REJECT;
			end
			if (state_q == bda_pkg::ST_REQ && req_bad) begin
				status_q <= bda_pkg::STATUS_DENY;
			end
			if (wr_en) begin
				colsum_q                <= lane_sum;
				row_vld_q[PW'(proc_q)]  <= 1'b1;
			end

			// seed the safety scan from the free vector
			if (state_q == bda_pkg::ST_SAFE_INIT) begin
				work_q     <= free_w;
				finished_q <= '0;
				count_q    <= '0;
				progress_q <= 1'b0;
				rd_idx_q   <= '0;
			end

			// advance the scan one row per cycle
			if (state_q == bda_pkg::ST_SAFE_SCAN) begin
				rd_idx_q <= (rd_idx_q == PW'(NUM_PROCESSES - 1)) ? '0 : rd_idx_q + PW'(1);
				if (fit) begin
					work_q                  <= lane_sum;
					finished_q[eval_idx_s1] <= 1'b1;
					count_q                 <= count_next;
				end
				if (eval_vld_s1) begin
					progress_q <= eval_last ? 1'b0 : (progress_q || fit);
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == bda_pkg::ST_DONE && out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bda_pkg::ST_DONE && out_load) begin
			res_status_q <= status_q;
			res_safe_q   <= (mode_q == bda_pkg::MODE_SAFETY) &&
			                (count_q == CNTW'(NUM_PROCESSES));
			res_count_q  <= bda_pkg::CNT_OUT_W'(count_q);
			res_free_q   <= free_w;
		end
	end

	// Pack the result
	always_comb begin
		m_tdata = '0;
		m_tdata[bda_pkg::STATUS_W-1:0] = res_status_q;
		m_tdata[bda_pkg::OUT_SAFE_BIT] = res_safe_q;
		m_tdata[bda_pkg::OUT_CNT_LSB +: bda_pkg::CNT_OUT_W] = res_count_q;
		for (int k = 0; k < NUM_RESOURCES; k++) begin
			m_tdata[bda_pkg::OUT_FREE_LSB + k * bda_pkg::TOT_W +: bda_pkg::TOT_W] = res_free_q[k];
		end
	end

	assign m_tvalid = m_valid_q;

`ifndef SYNTHESIS
	// Finished count always matches the finished marks during a scan
	a_count_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bda_pkg::ST_SAFE_SCAN) |-> ($countones(finished_q) == 32'(count_q)))
		else $error("finished count out of step with finished marks");

	// Row writes only target a process inside the table
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> proc_ok_q)
		else $error("row write to a process out of range");

	// A rejected load leaves the column sums untouched
	a_reject_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bda_pkg::ST_LOAD && load_bad) |=> $stable(colsum_q))
		else $error("column sums changed on a rejected load");

	// A refused request leaves the column sums untouched
	a_deny_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bda_pkg::ST_REQ && req_bad) |=> $stable(colsum_q))
		else $error("column sums changed on a denied request");

	// The scan never counts more processes than the table holds
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bda_pkg::ST_SAFE_SCAN) |-> (32'(count_q) <= NUM_PROCESSES))
		else $error("finished count beyond process count");
`endif

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the banker's algorithm resource manager. A ledger
// class tracks held and need tables, column sums and totals, predicts one
// result per request, and compares each result field by field. Directed loads,
// grants, denials and safety checks come first. Random phases under several
// total settings follow, most of them with idle gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb;
	import bda_pkg::*;

	localparam int NPROC        = 16;
	localparam int STALL_LIMIT  = 4000;
	localparam int CFG_SETTLE   = 8;
	localparam int DRAIN_CYCLES = 16;

	localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_0 = 3'd0;

	typedef struct packed {
		logic [MODE_W-1:0]             mode;
		logic [PROC_W-1:0]             proc;
		logic [KINDS-1:0][AMT_W-1:0]   amt;
		logic [KINDS-1:0][AMT_W-1:0]   lim;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]           status;
		logic                          safe;
		logic [CNT_OUT_W-1:0]          finished;
		logic [KINDS-1:0][TOT_W-1:0]   free;
	} reply_t;

	// Ledger of the allocation state and the queue of predicted results
	class resource_ledger;
		logic [TOT_W-1:0] total [KINDS];
		logic [AMT_W-1:0] held [NPROC][KINDS];
		logic [AMT_W-1:0] need [NPROC][KINDS];
		logic [TOT_W-1:0] col_sum [KINDS];
		reply_t expected_replies [$];
		int mismatches;

		function new();
			mismatches = 0;
			for (int k = 0; k < KINDS; k++) begin
				total[k] = '0;
				col_sum[k] = '0;
				for (int i = 0; i < NPROC; i++) begin
					held[i][k] = '0;
					need[i][k] = '0;
				end
			end
		endfunction

		// Free units saturate at zero when a total drops below the held sum
		function int free_units(int k);
			if (col_sum[k] >= total[k])
				return 0;
			return int'(total[k]) - int'(col_sum[k]);
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		// Apply one accepted request and queue the result it must produce
		function void note_request(cmd_t c);
			reply_t r;
			bit ok;
			bit progress;
			bit fits;
			bit done [NPROC];
			int work [KINDS];
			int p;
			int count;
			r = '0;
			p = int'(c.proc);
			ok = 1'b1;
			count = 0;
			case (c.mode)
			MODE_LOAD: begin
				for (int k = 0; k < KINDS; k++)
					if (c.lim[k] < c.amt[k] ||
					    int'(col_sum[k]) - int'(held[p][k]) + int'(c.amt[k]) > int'(total[k]))
						ok = 1'b0;
				if (ok) begin
					for (int k = 0; k < KINDS; k++) begin
						col_sum[k] = col_sum[k] - TOT_W'(held[p][k]) + TOT_W'(c.amt[k]);
						held[p][k] = c.amt[k];
						need[p][k] = c.lim[k] - c.amt[k];
					end
				end
				r.status = ok ? STATUS_OK : STATUS_REJECT;
			end
			MODE_REQUEST: begin
				for (int k = 0; k < KINDS; k++)
					if (c.amt[k] > need[p][k] || int'(c.amt[k]) > free_units(k))
						ok = 1'b0;
				if (ok) begin
					for (int k = 0; k < KINDS; k++) begin
						held[p][k] = held[p][k] + c.amt[k];
						need[p][k] = need[p][k] - c.amt[k];
						col_sum[k] = col_sum[k] + TOT_W'(c.amt[k]);
					end
				end
				r.status = ok ? STATUS_OK : STATUS_DENY;
			end
			MODE_SAFETY: begin
				for (int k = 0; k < KINDS; k++)
					work[k] = free_units(k);
				for (int i = 0; i < NPROC; i++)
					done[i] = 1'b0;
				// Repeat passes until one of them finishes nobody
				progress = 1'b1;
				while (progress) begin
					progress = 1'b0;
					for (int i = 0; i < NPROC; i++) begin
						if (!done[i]) begin
							fits = 1'b1;
							for (int k = 0; k < KINDS; k++)
								if (int'(need[i][k]) > work[k])
									fits = 1'b0;
							if (fits) begin
								for (int k = 0; k < KINDS; k++)
									work[k] += int'(held[i][k]);
								done[i] = 1'b1;
								count++;
								progress = 1'b1;
							end
						end
					end
				end
				r.finished = CNT_OUT_W'(count);
				r.safe = (count == NPROC);
			end
			default: ;
			endcase
			for (int k = 0; k < KINDS; k++)
				r.free[k] = TOT_W'(free_units(k));
			expected_replies.push_back(r);
		endfunction

		function void compare_field(string name, logic [TOT_W-1:0] want,
		                            logic [TOT_W-1:0] seen);
			if (seen !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on %s: expected %0d, got %0d", name, want, seen);
			end
		endfunction

		// Check one accepted result against the oldest prediction
		function void check_result(logic [OUT_DATA_W-1:0] d);
			reply_t want;
			reply_t got;
			got.status = d[STATUS_W-1:0];
			got.safe = d[OUT_SAFE_BIT];
			got.finished = d[OUT_CNT_LSB +: CNT_OUT_W];
			for (int k = 0; k < KINDS; k++)
				got.free[k] = d[OUT_FREE_LSB + k * TOT_W +: TOT_W];
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no request pending: %h", d);
				return;
			end
			want = expected_replies.pop_front();
			compare_field("status", TOT_W'(want.status), TOT_W'(got.status));
			compare_field("safe", TOT_W'(want.safe), TOT_W'(got.safe));
			compare_field("finished_count", TOT_W'(want.finished), TOT_W'(got.finished));
			for (int k = 0; k < KINDS; k++)
				compare_field($sformatf("free_%0d", k), want.free[k], got.free[k]);
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_W-1:0]     s_tdata;
	logic [MODE_W-1:0]        s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_W-1:0]    m_tdata;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [TOT_W-1:0]         cfg_data;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;
	resource_ledger ledger = new();

	bankers_deadlock_avoidance dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Drain results with random back-pressure
	initial begin
		m_tready <= 1'b0;
		forever @(posedge clk) begin
			if (arst_n && m_tvalid && m_tready)
				ledger.check_result(m_tdata);
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Abort when nothing moves for too long
	initial begin
		forever @(posedge clk) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Offer one request, with random idle cycles ahead of it
	task automatic send_cmd(input cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c.mode;
		s_tdata <= {{(IN_DATA_W - PROC_W - 2 * KINDS * AMT_W){1'b0}}, c.lim, c.amt, c.proc};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ledger.note_request(c);
	endtask

	function automatic cmd_t uniform_cmd(logic [MODE_W-1:0] m, int p, int a, int l);
		cmd_t c;
		c.mode = m;
		c.proc = PROC_W'(p);
		for (int k = 0; k < KINDS; k++) begin
			c.amt[k] = AMT_W'(a);
			c.lim[k] = AMT_W'(l);
		end
		return c;
	endfunction

	// Wait for the block to go idle, then rewrite every total
	task automatic program_totals(input logic [KINDS-1:0][TOT_W-1:0] tot);
		s_tvalid <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		for (int k = 0; k < KINDS; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_TOTAL_0 + CFG_IDX_W'(k);
			cfg_data <= tot[k];
			@(posedge clk);
			ledger.total[k] = tot[k];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_totals(input int lo, input int hi);
		logic [KINDS-1:0][TOT_W-1:0] tot;
		for (int k = 0; k < KINDS; k++)
			tot[k] = TOT_W'($urandom_range(lo, hi));
		program_totals(tot);
	endtask

	// Mostly well-formed loads and requests, some broken ones, safety checks and some noise
	task automatic run_random(input int count);
		cmd_t c;
		logic [95:0] noise;
		int pick;
		int room;
		int cap;
		int bad_kind;
		bit well_formed;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			well_formed = ($urandom_range(9) < 7);
			noise = {$urandom, $urandom, $urandom};
			c = noise[$bits(cmd_t)-1:0];
			if (pick < 35) begin
				c.mode = MODE_LOAD;
				if (well_formed) begin
					for (int k = 0; k < KINDS; k++) begin
						room = int'(ledger.total[k]) - int'(ledger.col_sum[k])
						       + int'(ledger.held[c.proc][k]);
						if (room < 0)
							room = 0;
						if (room > 255)
							room = 255;
						c.amt[k] = AMT_W'(($urandom_range(3) == 0) ? room
						                                            : $urandom_range(0, room));
						c.lim[k] = AMT_W'($urandom_range(int'(c.amt[k]), 255));
					end
				end
			end else if (pick < 70) begin
				c.mode = MODE_REQUEST;
				bad_kind = $urandom_range(KINDS - 1);
				for (int k = 0; k < KINDS; k++) begin
					cap = ledger.free_units(k);
					if (cap > int'(ledger.need[c.proc][k]))
						cap = int'(ledger.need[c.proc][k]);
					if (!well_formed && k == bad_kind)
						c.amt[k] = AMT_W'(cap + 1);
					else
						c.amt[k] = AMT_W'(($urandom_range(3) == 0) ? cap
						                                            : $urandom_range(0, cap));
				end
			end else if (pick < 86) begin
				c.mode = MODE_SAFETY;
			end
			send_cmd(c);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= MODE_LOAD;
		cfg_we <= 1'b0;
		cfg_index <= REG_TOTAL_0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 28;
		recv_idle_pct = 51;

		// Directed: full totals, extremes, grants and denials, a safety check, an unused mode
		program_totals({KINDS{12'hFFF}});
		send_cmd(uniform_cmd(MODE_LOAD, 0, 0, 0));
		send_cmd(uniform_cmd(MODE_LOAD, 15, 255, 255));
		send_cmd(uniform_cmd(MODE_LOAD, 1, 10, 5));
		send_cmd(uniform_cmd(MODE_LOAD, 3, 0, 255));
		send_cmd(uniform_cmd(MODE_REQUEST, 3, 255, 0));
		send_cmd(uniform_cmd(MODE_REQUEST, 3, 1, 0));
		send_cmd(uniform_cmd(MODE_REQUEST, 1, 1, 0));
		send_cmd(uniform_cmd(MODE_REQUEST, 0, 0, 0));
		send_cmd(uniform_cmd(MODE_SAFETY, 0, 0, 0));
		send_cmd(uniform_cmd(MODE_UNUSED, 15, 255, 255));

		// Directed: totals below the held sum, then free space runs out
		program_totals({KINDS{12'd300}});
		send_cmd(uniform_cmd(MODE_SAFETY, 0, 0, 0));
		send_cmd(uniform_cmd(MODE_REQUEST, 3, 0, 0));
		send_cmd(uniform_cmd(MODE_LOAD, 4, 0, 10));
		send_cmd(uniform_cmd(MODE_LOAD, 3, 0, 0));
		send_cmd(uniform_cmd(MODE_LOAD, 4, 40, 200));
		send_cmd(uniform_cmd(MODE_LOAD, 5, 10, 60));
		send_cmd(uniform_cmd(MODE_REQUEST, 4, 5, 0));
		send_cmd(uniform_cmd(MODE_REQUEST, 4, 1, 0));
		send_cmd(uniform_cmd(MODE_SAFETY, 0, 0, 0));

		// Random phases across several total settings
		program_totals({KINDS{12'hFFF}});
		run_random(250);
		random_totals(100, 1000);
		run_random(250);

		send_idle_pct = 51;
		recv_idle_pct = 28;
		program_totals({KINDS{12'h000}});
		run_random(60);
		random_totals(1000, 4095);
		run_random(250);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_totals(0, 600);
		run_random(250);
		random_totals(0, 4095);
		run_random(240);

		// Drain outstanding results
		s_tvalid <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/bda_pkg.sv
rtl/core/bankers_deadlock_avoidance.sv
bench/tb.sv
